/* hdl/chre_pkg.sv */
// chre_pkg: shared types and constants for the consistent hash ring engine.
// No dependencies.
package chre_pkg;

  localparam int unsigned ServerW = 17;
  localparam int unsigned HashW   = 32;
  localparam logic [31:0] DjbSeed     = 32'd5381;
  localparam logic [31:0] MixMult     = 32'h045d9f3b;
  localparam logic [31:0] LabelStride = 32'd100000;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_KEY    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Command passed from the front end to the ring engine.
  typedef struct packed {
    action_t             op;
    logic [ServerW-1:0]  server;
    logic [HashW-1:0]    digest;
  } cmd_t;

endpackage

/* hdl/chre_if.sv */
// chre_if: valid/ready channel carrying the input or result word.
// Depends on chre_pkg.
interface chre_in_if;
  import chre_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [ServerW-1:0] server_number;
  logic [7:0]         key_byte;
  logic               key_last;
  modport source (output valid, action, server_number, key_byte, key_last, input ready);
  modport sink (input valid, action, server_number, key_byte, key_last, output ready);
endinterface

interface chre_out_if;
  import chre_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ServerW-1:0] owner_server;
  logic [7:0]         point_index;
  logic [HashW-1:0]   key_digest;
  modport source (output valid, status, owner_server, point_index, key_digest, input ready);
  modport sink (input valid, status, owner_server, point_index, key_digest, output ready);
endinterface

/* hdl/consistent_hash_ring_engine_top.sv */
// Consistent hash ring engine
// in channel (chre_in_if sink): action 0 adds a server (REPLICAS points),
//   1 removes every point of a server, 2 streams one key byte; key_last
//   closes a key and yields a lookup. Action 3 is dropped.
// out channel (chre_out_if source): one word per add, remove and last key
//   byte: status (ok/full/absent/empty), owner_server, point_index and
//   the djb2 key_digest.
// Add, remove and lookup each walk the ring memory one entry per cycle.
// A two-word queue lets key bytes keep streaming while the engine works, until full.
// Reset empties the ring and reseeds the key hash to 5381. While the
// receiver stalls the result word holds and the engine takes no command.
// Depends on chre_pkg, chre_if, chre_front, chre_back.
module consistent_hash_ring_engine_top #(
  parameter int unsigned RING_POINTS = 256,
  parameter int unsigned REPLICAS    = 3
) (
  input logic  clk,
  input logic  rst,
  chre_in_if.sink    in_ch,
  chre_out_if.source out_ch
);
  import chre_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  chre_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .in_action (in_ch.action), .in_server (in_ch.server_number),
    .in_byte (in_ch.key_byte), .in_last (in_ch.key_last),
    .cmd_valid, .cmd_ready, .cmd
  );

  chre_back #(.RING_POINTS(RING_POINTS), .REPLICAS(REPLICAS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid (out_ch.valid), .res_ready (out_ch.ready),
    .res_status (out_ch.status), .res_owner (out_ch.owner_server),
    .res_index (out_ch.point_index), .res_digest (out_ch.key_digest)
  );
endmodule

/* hdl/chre_front.sv */
// chre_front: accepts input words, folds key bytes into djb2, and queues
// commands for the ring engine. Depends on chre_pkg.
module chre_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [chre_pkg::ServerW-1:0] in_server,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output chre_pkg::cmd_t      cmd
);
  import chre_pkg::*;

  // Two-entry command queue.
  cmd_t        q [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic [31:0] acc;
  logic [31:0] digest;
  logic        acc_in, push, pop;

  assign digest    = (acc << 5) + acc + {24'd0, in_byte};
  assign in_ready  = (cnt != 2'd2);
  assign acc_in    = in_valid && in_ready;
  assign push      = acc_in && (in_action == ACT_ADD || in_action == ACT_REMOVE ||
                                (in_action == ACT_KEY && in_last));
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign pop       = cmd_valid && cmd_ready;

  // Advance accumulator and queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= DjbSeed;
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc_in && in_action == ACT_KEY) begin
        acc <= in_last ? DjbSeed : digest;
      end
      if (push) begin
        q[wp]        <= '{op: action_t'(in_action), server: in_server, digest: digest};
        wp           <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* hdl/chre_back.sv */
// chre_back: ring engine; sorted memory with insert, delete and search
// sequenced one entry per cycle. Depends on chre_pkg.
module chre_back #(
  parameter int unsigned RING_POINTS = 256,
  parameter int unsigned REPLICAS    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  chre_pkg::cmd_t      cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [1:0]          res_status,
  output logic [chre_pkg::ServerW-1:0] res_owner,
  output logic [7:0]          res_index,
  output logic [chre_pkg::HashW-1:0]   res_digest
);
  import chre_pkg::*;

  localparam int unsigned AW = (RING_POINTS > 1) ? $clog2(RING_POINTS) : 1;
  localparam int unsigned CW = $clog2(RING_POINTS + 1);
  localparam int unsigned RW = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
  localparam logic [CW:0] RingMax = (CW+1)'(RING_POINTS);
  localparam logic [CW:0] RepN    = (CW+1)'(REPLICAS);

  typedef enum logic [3:0] {
    S_IDLE, S_MIX0, S_MIX1, S_MIX2, S_MIX3, S_SRCH, S_SHIFT, S_PUT,
    S_RSCAN, S_LSRCH, S_LREAD, S_OUT
  } state_t;

  state_t              state;
  cmd_t                cur;
  logic [HashW-1:0]    mem_h [RING_POINTS];
  logic [ServerW-1:0]  mem_o [RING_POINTS];
  logic [HashW-1:0]    rd_h;
  logic [ServerW-1:0]  rd_o;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr, wr;
  logic [RW-1:0]       rep;
  logic [HashW-1:0]    x, h;
  logic                found, rd_ok;
  logic [CW-1:0]       rd_addr;
  logic                we;
  logic [AW-1:0]       we_addr;
  logic [HashW-1:0]    we_h;
  logic [ServerW-1:0]  we_o;

  // Registered memory read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_h[we_addr] <= we_h;
      mem_o[we_addr] <= we_o;
    end
    rd_h <= mem_h[rd_addr[AW-1:0]];
    rd_o <= mem_o[rd_addr[AW-1:0]];
  end

  assign cmd_ready = (state == S_IDLE) && !res_valid;

  // Sequencer: read address chosen combinationally, data used next cycle.
  always_comb begin
    rd_addr = ptr;
    we      = 1'b0;
    we_addr = ptr[AW-1:0];
    we_h    = rd_h;
    we_o    = rd_o;
    case (state)
      // Prime entry 0 for the first search or scan step.
      S_IDLE, S_MIX0, S_MIX1, S_MIX2, S_MIX3: rd_addr = '0;
      S_SHIFT: begin
        // ptr holds the destination; once primed, rd_h is entry ptr-1.
        rd_addr = rd_ok ? ptr - CW'(2) : ptr - CW'(1);
        we      = rd_ok;
      end
      S_PUT: begin
        we   = 1'b1;
        we_h = h;
        we_o = cur.server;
      end
      S_RSCAN: begin
        rd_addr = ptr + CW'(1);
        we      = rd_ok && (rd_o != cur.server);
        we_addr = wr[AW-1:0];
      end
      S_SRCH: rd_addr = ptr + CW'(1);
      // Wrap the read to entry 0 after the last point.
      S_LSRCH: rd_addr = (ptr + CW'(1) == count) ? '0 : ptr + CW'(1);
      default: rd_addr = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur        <= cmd;
          res_owner  <= '0;
          res_index  <= '0;
          ptr        <= '0;
          wr         <= '0;
          rep        <= '0;
          found      <= 1'b0;
          case (cmd.op)
            ACT_ADD: begin
              res_digest <= '0;
              rd_ok      <= 1'b1;
              if ({1'b0, count} + RepN > RingMax) begin
                res_status <= ST_FULL;
                state      <= S_OUT;
              end else begin
                res_status <= ST_OK;
                state      <= S_MIX0;
              end
            end
            ACT_REMOVE: begin
              res_status <= ST_OK;
              res_digest <= '0;
              rd_ok      <= (count != '0);
              state      <= S_RSCAN;
            end
            default: begin
              res_digest <= cmd.digest;
              rd_ok      <= 1'b1;
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_OUT;
              end else begin
                res_status <= ST_OK;
                state      <= S_LSRCH;
              end
            end
          endcase
        end
        S_MIX0: begin
          x     <= 32'(rep) * LabelStride + {15'd0, cur.server};
          state <= S_MIX1;
        end
        S_MIX1: begin
          x     <= ((x >> 16) ^ x) * MixMult;
          state <= S_MIX2;
        end
        S_MIX2: begin
          x     <= ((x >> 16) ^ x) * MixMult;
          state <= S_MIX3;
        end
        S_MIX3: begin
          h     <= (x >> 16) ^ x;
          ptr   <= '0;
          state <= (count == '0) ? S_PUT : S_SRCH;
        end
        // Find first entry with hash >= h; rd_h is entry ptr.
        S_SRCH: begin
          if (rd_h >= h) begin
            wr    <= ptr;
            ptr   <= count;
            rd_ok <= 1'b0;
            state <= S_SHIFT;
          end else if (ptr + CW'(1) == count) begin
            ptr   <= count;
            state <= S_PUT;
          end else begin
            ptr <= ptr + CW'(1);
          end
        end
        // Prime the read of ptr-1, then move one entry up per cycle.
        S_SHIFT: begin
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else if (ptr - CW'(1) == wr) begin
            ptr   <= wr;
            state <= S_PUT;
          end else begin
            ptr <= ptr - CW'(1);
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          if (rep == RW'(REPLICAS - 1)) begin
            state <= S_OUT;
          end else begin
            rep   <= rep + RW'(1);
            state <= S_MIX0;
          end
        end
        // Compact entries not owned by the server; rd is entry ptr.
        S_RSCAN: begin
          if (!rd_ok) begin
            count      <= wr;
            res_status <= found ? ST_OK : ST_ABSENT;
            state      <= S_OUT;
          end else begin
            if (rd_o == cur.server) found <= 1'b1;
            else wr <= wr + CW'(1);
            rd_ok <= (ptr + CW'(1) != count);
            ptr   <= ptr + CW'(1);
          end
        end
        S_LSRCH: begin
          if (rd_h >= cur.digest) begin
            res_owner <= rd_o;
            res_index <= 8'(ptr);
            state     <= S_OUT;
          end else if (ptr + CW'(1) == count) begin
            ptr   <= '0;
            state <= S_LREAD;
          end else begin
            ptr <= ptr + CW'(1);
          end
        end
        // No point at or above the key: take the owner of entry 0.
        S_LREAD: begin
          res_owner <= rd_o;
          res_index <= '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
